// File: sv/srrw_pkg.sv
// Shared constants, types and sequence helpers for the selective-repeat receive window.
// No dependencies; every other file in this folder imports it.
package srrw_pkg;

  localparam int SEQ_COUNT = 16;
  localparam int WINDOW    = 8;
  localparam int BLOCK     = 8;

  localparam int HDR_W       = 8;
  localparam int TIMEOUT_BIT = 7;
  localparam int KIND_W      = 2;
  localparam int SEQ_OUT_W   = 4;

  localparam int SEQ_W  = $clog2(SEQ_COUNT);
  localparam int STEP_W = $clog2(SEQ_COUNT + 1);
  localparam int J_W    = $clog2(WINDOW + SEQ_COUNT + 1);
  localparam int I_W    = $clog2(BLOCK + 1);
  localparam int MOD_W  = HDR_W + SEQ_W + 1;

  localparam logic [SEQ_W-1:0] LAST_SEQ      = SEQ_W'(SEQ_COUNT - 1);
  localparam logic [SEQ_W-1:0] BLOCK_END_RST = SEQ_W'(BLOCK % SEQ_COUNT);

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER,
    KIND_NAK,
    KIND_STOP
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_DELIV,
    ST_NAK,
    ST_RECOMP,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    RD_S,
    RD_FP,
    RD_SCAN,
    RD_WALK
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    stop;
    logic    mark;
    logic    steps_clr;
    logic    deliv_step;
    logic    nak_init;
    logic    nak_step;
    logic    rc_init;
    logic    rc_step;
    logic    flush;
    rd_sel_t rd_sel;
  } srrw_cmd_t;

  typedef struct packed {
    logic map_bit;
    logic s_is_fp;
    logic nak_req;
    logic steps_ok;
    logic scan_open;
    logic rc_done;
    logic pend_valid;
    logic out_free;
  } srrw_status_t;

  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
    return (s == LAST_SEQ) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_prev(input logic [SEQ_W-1:0] s);
    return (s == '0) ? LAST_SEQ : s - 1'b1;
  endfunction

  // Restoring reduction of the 7-bit header sequence field modulo SEQ_COUNT.
  function automatic logic [SEQ_W-1:0] seq_mod(input logic [HDR_W-2:0] v);
    logic [MOD_W-1:0] r;
    r = MOD_W'(v);
    for (int sh = HDR_W - 2; sh >= 0; sh--) begin
      if (r >= (MOD_W'(SEQ_COUNT) << sh)) begin
        r = r - (MOD_W'(SEQ_COUNT) << sh);
      end
    end
    return r[SEQ_W-1:0];
  endfunction

endpackage

// File: sv/srrw_ctrl.sv
// Controller state machine for the receive window: sequences mark, delivery walk,
// NAK scan, block-end search and result flush. Depends on srrw_pkg.
module srrw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   crc_ok,
  input  logic                   has_payload,
  input  srrw_pkg::srrw_status_t status,
  output logic                   in_ready,
  output srrw_pkg::srrw_cmd_t    cmd
);
  import srrw_pkg::*;

  state_t state;
  state_t state_next;
  logic   stall;
  logic   deliv_more;
  logic   scan_more;

  assign stall      = status.pend_valid && !status.out_free;
  assign deliv_more = status.map_bit && status.steps_ok;
  assign scan_more  = status.scan_open && status.steps_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && crc_ok) begin
          state_next = has_payload ? ST_MARK : ST_FLUSH;
        end
      end
      ST_MARK: begin
        if (!status.map_bit && status.s_is_fp) begin
          state_next = ST_DELIV;
        end else begin
          state_next = status.nak_req ? ST_NAK : ST_FLUSH;
        end
      end
      ST_DELIV: begin
        if (!deliv_more) begin
          state_next = status.nak_req ? ST_NAK : ST_FLUSH;
        end
      end
      ST_NAK: begin
        if (!scan_more) begin
          state_next = ST_RECOMP;
        end
      end
      ST_RECOMP: begin
        if (status.rc_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.rd_sel = RD_S;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && crc_ok) begin
          cmd.load = has_payload;
          cmd.stop = !has_payload;
        end
      end
      ST_MARK: begin
        cmd.rd_sel = RD_S;
        cmd.mark   = !status.map_bit;
        if (!status.map_bit && status.s_is_fp) begin
          cmd.steps_clr = 1'b1;
        end else if (status.nak_req) begin
          cmd.nak_init  = 1'b1;
          cmd.steps_clr = 1'b1;
        end
      end
      ST_DELIV: begin
        cmd.rd_sel = RD_FP;
        if (deliv_more) begin
          // hold the walk while the pending result cannot move out
          cmd.deliv_step = !stall;
        end else if (status.nak_req) begin
          cmd.nak_init  = 1'b1;
          cmd.steps_clr = 1'b1;
        end
      end
      ST_NAK: begin
        cmd.rd_sel = RD_SCAN;
        if (scan_more) begin
          cmd.nak_step = status.map_bit || !stall;
        end else begin
          cmd.rc_init   = 1'b1;
          cmd.steps_clr = 1'b1;
        end
      end
      ST_RECOMP: begin
        cmd.rd_sel  = RD_WALK;
        cmd.rc_step = 1'b1;
      end
      ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/srrw_dp.sv
// Datapath for the receive window: received bitmap, window pointers, walk counters,
// one-deep pending result and the output register. Depends on srrw_pkg.
module srrw_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [srrw_pkg::HDR_W-1:0]       header_byte,
  input  logic                             out_ready,
  input  srrw_pkg::srrw_cmd_t              cmd,
  output srrw_pkg::srrw_status_t           status,
  output logic                             out_valid,
  output logic [srrw_pkg::KIND_W-1:0]      out_kind,
  output logic [srrw_pkg::SEQ_OUT_W-1:0]   out_seq,
  output logic                             out_last
);
  import srrw_pkg::*;

  logic [SEQ_COUNT-1:0] rx_map;
  logic [SEQ_W-1:0]     first_pending;
  logic [SEQ_W-1:0]     block_end;
  logic [SEQ_W-1:0]     cur_seq;
  logic [SEQ_W-1:0]     scan_seq;
  logic [SEQ_W-1:0]     walk_seq;
  logic                 nak_req;
  logic [STEP_W-1:0]    steps;
  logic [J_W-1:0]       walk_dist;
  logic [I_W-1:0]       walk_cnt;
  logic                 pend_valid;
  kind_t                pend_kind;
  logic [SEQ_W-1:0]     pend_seq;

  logic [SEQ_W-1:0]     in_seq;
  logic [SEQ_W-1:0]     walk_next;
  logic [SEQ_W-1:0]     rd_addr;
  logic                 map_bit;
  logic                 inner_more;
  logic                 outer_more;
  logic                 out_free;
  logic                 emit_valid;
  kind_t                emit_kind;
  logic [SEQ_W-1:0]     emit_seq;

  assign in_seq    = seq_mod(header_byte[HDR_W-2:0]);
  assign walk_next = seq_next(walk_seq);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_S:    rd_addr = cur_seq;
      RD_FP:   rd_addr = first_pending;
      RD_SCAN: rd_addr = scan_seq;
      RD_WALK: rd_addr = walk_next;
      default: rd_addr = cur_seq;
    endcase
  end

  assign map_bit = rx_map[rd_addr];

  // Block-end search: the inner run continues over received slots, the outer
  // loop while more slots of the block fit inside the window.
  assign inner_more = map_bit && (steps < STEP_W'(SEQ_COUNT - 1));
  assign outer_more = (walk_cnt < I_W'(BLOCK - 1)) && (walk_dist < J_W'(WINDOW - 1));

  always_comb begin
    status.map_bit    = map_bit;
    status.s_is_fp    = (cur_seq == first_pending);
    status.nak_req    = nak_req;
    status.steps_ok   = (steps < STEP_W'(SEQ_COUNT));
    status.scan_open  = (scan_seq != seq_next(block_end));
    status.rc_done    = !inner_more && !outer_more;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  always_comb begin
    emit_valid = cmd.stop || cmd.deliv_step || (cmd.nak_step && !map_bit);
    emit_kind  = KIND_STOP;
    emit_seq   = '0;
    if (cmd.deliv_step) begin
      emit_kind = KIND_DELIVER;
      emit_seq  = first_pending;
    end else if (cmd.nak_step) begin
      emit_kind = KIND_NAK;
      emit_seq  = scan_seq;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_map        <= '0;
      first_pending <= '0;
      block_end     <= BLOCK_END_RST;
      nak_req       <= 1'b0;
    end else begin
      if (cmd.stop) begin
        rx_map        <= '0;
        first_pending <= '0;
        block_end     <= BLOCK_END_RST;
      end
      if (cmd.load) begin
        nak_req <= header_byte[TIMEOUT_BIT] || (in_seq == block_end);
      end
      if (cmd.mark) begin
        rx_map[cur_seq] <= 1'b1;
      end
      if (cmd.deliv_step) begin
        rx_map[seq_prev(first_pending)] <= 1'b0;
        if (first_pending == block_end) begin
          block_end <= seq_next(block_end);
        end
        first_pending <= seq_next(first_pending);
      end
      if (cmd.rc_init) begin
        block_end <= first_pending;
      end
      if (cmd.rc_step && !inner_more && (walk_dist < J_W'(WINDOW))) begin
        block_end <= walk_next;
      end
    end
  end

  // walk registers: only read in states that load them first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_seq <= in_seq;
    end
    if (cmd.steps_clr) begin
      steps <= '0;
    end else if (cmd.deliv_step || cmd.nak_step) begin
      steps <= steps + 1'b1;
    end else if (cmd.rc_step) begin
      steps <= inner_more ? steps + 1'b1 : '0;
    end
    if (cmd.nak_init) begin
      scan_seq <= first_pending;
    end else if (cmd.nak_step) begin
      scan_seq <= seq_next(scan_seq);
    end
    if (cmd.rc_init) begin
      walk_seq  <= first_pending;
      walk_dist <= '0;
      walk_cnt  <= I_W'(1);
    end else if (cmd.rc_step) begin
      walk_seq  <= walk_next;
      walk_dist <= walk_dist + 1'b1;
      if (!inner_more) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  // Results trail by one in the pending stage so the final one can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_valid) begin
        pend_valid <= 1'b1;
        out_valid  <= pend_valid || (out_valid && !out_ready);
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      pend_kind <= emit_kind;
      pend_seq  <= emit_seq;
      if (pend_valid) begin
        out_kind <= pend_kind;
        out_seq  <= SEQ_OUT_W'(pend_seq);
        out_last <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_kind <= pend_kind;
      out_seq  <= SEQ_OUT_W'(pend_seq);
      out_last <= 1'b1;
    end
  end

endmodule

// File: sv/selective_repeat_receive_window_unit.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    header_byte[7:0], crc_ok, has_payload
// out      out_valid / out_ready  kind[1:0], seq[3:0], last
//
// A bad-CRC request is dropped in the idle state. A stop frame passes through flush. A data
// frame is marked, then walks its in-order deliveries (at most SEQ_COUNT), and when it asks
// for a NAK list, scans the slots up to the block end (at most SEQ_COUNT) and searches for
// the new block end, before its results are flushed. The single bitmap read port is walked
// one slot per cycle while no result is stalled; out_ready held low while a result waits
// holds the walk. Reset is synchronous; the window is usable the cycle after.
// Top level: ties the controller to the datapath. Depends on srrw_pkg, srrw_ctrl, srrw_dp.
module selective_repeat_receive_window_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [srrw_pkg::HDR_W-1:0]       header_byte,
  input  logic                             crc_ok,
  input  logic                             has_payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [srrw_pkg::KIND_W-1:0]      kind,
  output logic [srrw_pkg::SEQ_OUT_W-1:0]   seq,
  output logic                             last
);
  import srrw_pkg::*;

  srrw_cmd_t    cmd;
  srrw_status_t status;

  srrw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .crc_ok      (crc_ok),
    .has_payload (has_payload),
    .status      (status),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  srrw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .header_byte (header_byte),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_kind    (kind),
    .out_seq     (seq),
    .out_last    (last)
  );

endmodule

// File: sv/srrw_checker.sv
// Port-level checks for the receive window, bound onto the top level.
// Depends on srrw_pkg and selective_repeat_receive_window_unit.
module srrw_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             crc_ok,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [srrw_pkg::KIND_W-1:0]      kind,
  input logic [srrw_pkg::SEQ_OUT_W-1:0]   seq,
  input logic                             last
);
  import srrw_pkg::*;

  // drop of a bad frame leaves the block free for the next request
  a_bad_crc_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !crc_ok |=> in_ready)
    else $error("bad-CRC request blocked input");

  a_good_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && crc_ok |=> !in_ready)
    else $error("good request did not occupy the block");

  a_stop_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_STOP) |-> last && (seq == '0))
    else $error("stop acknowledge malformed");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_DELIVER) || (kind == KIND_NAK) || (kind == KIND_STOP))
    else $error("illegal result kind");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(seq) && $stable(last))
    else $error("stalled result changed");

endmodule

bind selective_repeat_receive_window_unit srrw_checker u_srrw_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for selective_repeat_receive_window_unit: a queue-fed frame driver,
// an in-order result monitor and a predictor of the receive window state.
// Depends on srrw_pkg and the RTL top level.
module tb_top;
  import srrw_pkg::*;

  localparam int RANDOM_FRAMES = 85;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 22;
  localparam int DRAIN_CYCLES  = 100;
  localparam logic [HDR_W-1:0] STOP_HDR = HDR_W'(1) << TIMEOUT_BIT;

  typedef struct {
    logic [HDR_W-1:0] hdr;
    logic             crc;
    logic             pay;
    bit               drain;
  } frame_t;

  typedef struct {
    kind_t                kind;
    logic [SEQ_OUT_W-1:0] num;
    logic                 last;
  } window_res_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic [HDR_W-1:0]     header_byte = '0;
  logic                 crc_ok      = 1'b0;
  logic                 has_payload = 1'b0;
  logic                 out_ready   = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [KIND_W-1:0]    kind;
  logic [SEQ_OUT_W-1:0] seq;
  logic                 last;

  frame_t      req_q[$];
  window_res_t arrivals[$];
  int          expected_total = 0;
  int          results_seen   = 0;
  int          frames_taken   = 0;
  int          errors         = 0;
  int          cycles         = 0;
  logic        calm;

  // predicted window state
  logic             rx_map [SEQ_COUNT];
  logic [SEQ_W-1:0] first_pend;
  logic [SEQ_W-1:0] blk_end;

  selective_repeat_receive_window_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .header_byte (header_byte),
    .crc_ok      (crc_ok),
    .has_payload (has_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .seq         (seq),
    .last        (last)
  );

  always #4 clk = ~clk;

  // no idling on either side for a stretch in the middle of the random part
  assign calm = frames_taken >= 60 && frames_taken < 95;

  function automatic logic [SEQ_W-1:0] wrap_fwd(input logic [SEQ_W-1:0] s);
    return SEQ_W'((int'(s) + 1) % SEQ_COUNT);
  endfunction

  task automatic window_clear();
    foreach (rx_map[i]) rx_map[i] = 1'b0;
    first_pend = '0;
    blk_end    = SEQ_W'(BLOCK % SEQ_COUNT);
  endtask

  task automatic predict_frame(input logic [HDR_W-1:0] hdr, input logic crc, input logic pay);
    window_res_t      batch[$];
    window_res_t      res;
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] stop_at;
    logic [SEQ_W-1:0] k;
    logic             nak_req;
    int               steps;
    int               j;
    int               guard;
    if (!crc) return;
    if (!pay) begin
      res = '{KIND_STOP, '0, 1'b0};
      batch.insert(batch.size(), res);
      window_clear();
    end else begin
      s = SEQ_W'(int'(hdr[HDR_W-2:0]) % SEQ_COUNT);
      nak_req = hdr[TIMEOUT_BIT] || s == blk_end;
      if (!rx_map[s]) begin
        rx_map[s] = 1'b1;
        if (s == first_pend) begin
          steps = 0;
          // deliver the received run; the slot behind the walk is released
          while (rx_map[first_pend] && steps < SEQ_COUNT) begin
            res = '{KIND_DELIVER, SEQ_OUT_W'(first_pend), 1'b0};
            batch.insert(batch.size(), res);
            rx_map[SEQ_W'((int'(first_pend) + SEQ_COUNT - 1) % SEQ_COUNT)] = 1'b0;
            if (first_pend == blk_end) blk_end = wrap_fwd(blk_end);
            first_pend = wrap_fwd(first_pend);
            steps++;
          end
        end
      end
      if (nak_req) begin
        stop_at = wrap_fwd(blk_end);
        k = first_pend;
        steps = 0;
        while (k != stop_at && steps < SEQ_COUNT) begin
          if (!rx_map[k]) begin
            res = '{KIND_NAK, SEQ_OUT_W'(k), 1'b0};
            batch.insert(batch.size(), res);
          end
          k = wrap_fwd(k);
          steps++;
        end
        // hop over received runs, BLOCK-1 hops at most, within WINDOW slots
        k = first_pend;
        j = 0;
        blk_end = first_pend;
        for (int hop = 1; hop < BLOCK && j < WINDOW; hop++) begin
          guard = 0;
          do begin
            k = wrap_fwd(k);
            j++;
            guard++;
          end while (rx_map[k] && guard < SEQ_COUNT);
          if (j <= WINDOW) blk_end = k;
        end
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) arrivals.insert(arrivals.size(), batch[i]);
    expected_total += batch.size();
  endtask

  task automatic add_frame(input logic [HDR_W-1:0] hdr, input logic crc, input logic pay,
                           input bit drain);
    frame_t f;
    f.hdr   = hdr;
    f.crc   = crc;
    f.pay   = pay;
    f.drain = drain;
    req_q.insert(req_q.size(), f);
  endtask

  always @(posedge clk) begin : frame_driver
    frame_t nxt;
    bit     go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame(header_byte, crc_ok, has_payload);
        frames_taken <= frames_taken + 1;
      end
      if (!in_valid || in_ready) begin
        go = req_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        // hold a drain request until every outstanding result has been seen
        if (go && req_q[0].drain && expected_total != results_seen) go = 1'b0;
        if (go) begin
          nxt = req_q.pop_front();
          header_byte <= nxt.hdr;
          crc_ok      <= nxt.crc;
          has_payload <= nxt.pay;
        end
        in_valid <= go;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    window_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (arrivals.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual kind=%0d seq=%0d last=%0d",
                   $time, kind, seq, last);
        end else begin
          want = arrivals.pop_front();
          if (kind !== want.kind || seq !== want.num || last !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected kind/seq/last=%0d/%0d/%0d, actual %0d/%0d/%0d",
                     $time, want.kind, want.num, want.last, kind, seq, last);
          end
        end
      end
      out_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, arrivals.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int               win [8];
    int               tmp;
    int               pick;
    int               base;
    int               burst;
    int               n0;
    logic [HDR_W-1:0] hdr;
    logic [HDR_W-1:0] retry[$];
    window_clear();

    add_frame(8'h00, 1'b0, 1'b1, 1'b0);      // bad CRC on data
    add_frame(8'hFF, 1'b0, 1'b0, 1'b0);      // bad CRC on stop
    add_frame(8'h00, 1'b1, 1'b1, 1'b0);      // in-order delivery
    add_frame(8'h91, 1'b1, 1'b1, 1'b0);      // timeout flag, sequence above range
    add_frame(8'h01, 1'b1, 1'b1, 1'b0);      // duplicate
    add_frame(8'h7F, 1'b1, 1'b1, 1'b0);      // top of sequence field
    add_frame(8'hF3, 1'b1, 1'b1, 1'b0);      // gap, high bits set
    add_frame(8'hFF, 1'b1, 1'b0, 1'b0);      // stop with junk header
    add_frame(8'h08, 1'b1, 1'b1, 1'b0);      // hits block end after clear
    for (int s = 1; s < 8; s++) add_frame(HDR_W'(s), 1'b1, 1'b1, s == 1);
    add_frame(8'h00, 1'b1, 1'b1, 1'b0);      // long delivery walk
    add_frame(STOP_HDR, 1'b1, 1'b1, 1'b0);   // data with timeout flag
    add_frame(STOP_HDR, 1'b1, 1'b0, 1'b0);   // stop frame

    n0 = req_q.size();
    base = 0;
    burst = 0;
    while (req_q.size() - n0 < RANDOM_FRAMES) begin
      for (int i = 0; i < 8; i++) win[i] = (base + i) % SEQ_COUNT;
      for (int i = 7; i > 0; i--) begin
        pick = $urandom_range(0, i);
        tmp = win[i];
        win[i] = win[pick];
        win[pick] = tmp;
      end
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 99) < 5)
          add_frame(HDR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0);
        hdr = HDR_W'(win[i]);
        if ($urandom_range(0, 99) < 30) hdr[HDR_W-2:SEQ_W] = 3'($urandom_range(1, 7));
        hdr[TIMEOUT_BIT] = i == 7 || $urandom_range(0, 99) < 10;
        if ($urandom_range(0, 99) < 10) begin
          // drop on CRC, resend after the burst
          add_frame(hdr, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
          retry.insert(retry.size(), hdr);
        end else begin
          add_frame(hdr, 1'b1, 1'b1, burst == 4 && i == 0);
          if ($urandom_range(0, 99) < 8) add_frame(hdr, 1'b1, 1'b1, 1'b0);
        end
      end
      while (retry.size() > 0) begin
        hdr = retry.pop_front();
        hdr[TIMEOUT_BIT] = 1'b1;
        add_frame(hdr, 1'b1, 1'b1, 1'b0);
      end
      base = (base + 8) % SEQ_COUNT;
      burst++;
      if (burst % 5 == 0) begin
        add_frame(HDR_W'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        base = 0;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (req_q.size() != 0 || in_valid || arrivals.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
